// ===== src/tpsa_pkg.sv =====
// Shared constants, types and helper functions of the three-pool slot allocator.
package tpsa_pkg;

   // Pool geometry
   localparam int POOL_ENTRIES = 64;
   localparam int POOL_COUNT   = 3;
   localparam int SLOT_W       = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;

   // Field widths
   localparam int FUNC_W   = 1;
   localparam int POOL_W   = 2;
   localparam int ID_W     = 8;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;
   localparam int WIDE_W   = ID_W + 1;

   // Pool id ranges, one bit wider than the id so 3N always fits
   localparam logic [WIDE_W-1:0] POOL1_BASE = WIDE_W'(POOL_ENTRIES);
   localparam logic [WIDE_W-1:0] POOL2_BASE = WIDE_W'(2 * POOL_ENTRIES);
   localparam logic [WIDE_W-1:0] ID_LIMIT   = WIDE_W'(3 * POOL_ENTRIES);

   // Operation codes
   localparam logic [FUNC_W-1:0] FUNC_RESERVE = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 1'b1;

   // Pool codes
   localparam logic [POOL_W-1:0] POOL_AUDIO = 2'd0;
   localparam logic [POOL_W-1:0] POOL_HOST  = 2'd1;
   localparam logic [POOL_W-1:0] POOL_TRACK = 2'd2;
   localparam logic [POOL_W-1:0] POOL_NONE  = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the accepted request
      logic exec;   // carry out the held request and load the response
   } dp_cmd_type;

   typedef logic [POOL_ENTRIES-1:0] pool_map_type;

   // First global id of a pool
   function automatic logic [WIDE_W-1:0] pool_base(input logic [POOL_W-1:0] pool);
      logic [WIDE_W-1:0] base;
      case (pool)
         POOL_HOST:  base = POOL1_BASE;
         POOL_TRACK: base = POOL2_BASE;
         default:    base = '0;
      endcase
      return base;
   endfunction

   // Lowest set bit of a free map (priority encoder); zero if the map is empty
   function automatic logic [SLOT_W-1:0] lowest_free(input pool_map_type map);
      logic [SLOT_W-1:0] idx;
      idx = '0;
      for (int i = POOL_ENTRIES - 1; i >= 0; i--) begin
         if (map[i]) begin
            idx = SLOT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

// ===== src/tpsa_ifs.sv =====
// Request and response channel interfaces of the slot allocator.
interface tpsa_req_if;
   logic                             valid;
   logic                             ready;
   logic [tpsa_pkg::FUNC_W-1:0]      func;
   logic [tpsa_pkg::POOL_W-1:0]      pool_select;
   logic [tpsa_pkg::ID_W-1:0]        item_id;

   modport source (output valid, func, pool_select, item_id, input ready);
   modport sink   (input valid, func, pool_select, item_id, output ready);
endinterface

interface tpsa_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [tpsa_pkg::STATUS_W-1:0]    status;
   logic [tpsa_pkg::ID_W-1:0]        granted_id;
   logic [tpsa_pkg::COUNT_W-1:0]     free_count_audio;
   logic [tpsa_pkg::COUNT_W-1:0]     free_count_host;
   logic [tpsa_pkg::COUNT_W-1:0]     free_count_track;

   modport source (output valid, status, granted_id, free_count_audio, free_count_host,
                   free_count_track, input ready);
   modport sink   (input valid, status, granted_id, free_count_audio, free_count_host,
                   free_count_track, output ready);
endinterface

// ===== src/tpsa_datapath.sv =====
// Datapath: request holding registers, free maps, free counters and response registers.
module tpsa_datapath (
   input  logic                           clock,
   input  logic                           reset,
   input  tpsa_pkg::dp_cmd_type           cmd,
   input  logic [tpsa_pkg::FUNC_W-1:0]    req_func,
   input  logic [tpsa_pkg::POOL_W-1:0]    req_pool_select,
   input  logic [tpsa_pkg::ID_W-1:0]      req_item_id,
   output logic [tpsa_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tpsa_pkg::ID_W-1:0]      rsp_granted_id,
   output logic [tpsa_pkg::COUNT_W-1:0]   rsp_free_count_audio,
   output logic [tpsa_pkg::COUNT_W-1:0]   rsp_free_count_host,
   output logic [tpsa_pkg::COUNT_W-1:0]   rsp_free_count_track
);

   // Held request
   logic [tpsa_pkg::FUNC_W-1:0]   func_ff;
   logic [tpsa_pkg::POOL_W-1:0]   pool_ff;
   logic [tpsa_pkg::ID_W-1:0]     id_ff;

   // Pool state
   tpsa_pkg::pool_map_type        free_map_ff [tpsa_pkg::POOL_COUNT];
   tpsa_pkg::pool_map_type        free_map_in [tpsa_pkg::POOL_COUNT];
   logic [tpsa_pkg::COUNT_W-1:0]  count_ff    [tpsa_pkg::POOL_COUNT];
   logic [tpsa_pkg::COUNT_W-1:0]  count_in    [tpsa_pkg::POOL_COUNT];

   // Response registers
   logic [tpsa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [tpsa_pkg::ID_W-1:0]     granted_ff, granted_in;

   // Decode
   logic [tpsa_pkg::WIDE_W-1:0]   id_wide;
   logic [tpsa_pkg::WIDE_W-1:0]   slot_wide;
   logic [tpsa_pkg::POOL_W-1:0]   free_pool;
   logic [tpsa_pkg::SLOT_W-1:0]   free_slot;
   logic                          id_in_range;
   logic                          pool_valid;
   logic [tpsa_pkg::POOL_W-1:0]   tgt_pool;
   tpsa_pkg::pool_map_type        tgt_map;
   logic [tpsa_pkg::SLOT_W-1:0]   low_slot;
   logic [tpsa_pkg::WIDE_W-1:0]   grant_wide;

   // Pool and slot from a global id
   assign id_wide     = {1'b0, id_ff};
   assign id_in_range = id_wide < tpsa_pkg::ID_LIMIT;
   assign free_pool   = (id_wide >= tpsa_pkg::POOL2_BASE) ? tpsa_pkg::POOL_TRACK :
                        (id_wide >= tpsa_pkg::POOL1_BASE) ? tpsa_pkg::POOL_HOST :
                                                            tpsa_pkg::POOL_AUDIO;
   assign slot_wide   = id_wide - tpsa_pkg::pool_base(free_pool);
   assign free_slot   = slot_wide[tpsa_pkg::SLOT_W-1:0];

   // One pool is touched per request; selector three maps onto pool 0 but is never written
   assign pool_valid = (pool_ff != tpsa_pkg::POOL_NONE);
   always_comb begin
      if (func_ff == tpsa_pkg::FUNC_FREE) begin
         tgt_pool = free_pool;
      end else if (pool_valid) begin
         tgt_pool = pool_ff;
      end else begin
         tgt_pool = tpsa_pkg::POOL_AUDIO;
      end
   end

   assign tgt_map    = free_map_ff[tgt_pool];
   assign low_slot   = tpsa_pkg::lowest_free(tgt_map);
   assign grant_wide = tpsa_pkg::pool_base(tgt_pool)
                       + {{(tpsa_pkg::WIDE_W - tpsa_pkg::SLOT_W){1'b0}}, low_slot};

   // Next state of maps, counters and response
   always_comb begin
      free_map_in = free_map_ff;
      count_in    = count_ff;
      status_in   = status_ff;
      granted_in  = granted_ff;
      if (cmd.exec) begin
         status_in  = tpsa_pkg::STATUS_OK;
         granted_in = '0;
         if (func_ff == tpsa_pkg::FUNC_RESERVE) begin
            if (!pool_valid || (tgt_map == '0)) begin
               status_in = tpsa_pkg::STATUS_EMPTY;
            end else begin
               free_map_in[tgt_pool][low_slot] = 1'b0;
               count_in[tgt_pool]              = count_ff[tgt_pool]
                                                 - tpsa_pkg::COUNT_W'(1);
               granted_in                      = grant_wide[tpsa_pkg::ID_W-1:0];
            end
         end else begin
            if (!id_in_range) begin
               status_in = tpsa_pkg::STATUS_RANGE;
            end else if (!tgt_map[free_slot]) begin
               // a double free leaves map and count alone
               free_map_in[tgt_pool][free_slot] = 1'b1;
               count_in[tgt_pool]               = count_ff[tgt_pool]
                                                  + tpsa_pkg::COUNT_W'(1);
            end
         end
      end
   end

   // Request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         pool_ff <= req_pool_select;
         id_ff   <= req_item_id;
      end
   end

   // Pool state and response
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int p = 0; p < tpsa_pkg::POOL_COUNT; p++) begin
            free_map_ff[p] <= '1;
            count_ff[p]    <= tpsa_pkg::COUNT_W'(tpsa_pkg::POOL_ENTRIES);
         end
      end else begin
         free_map_ff <= free_map_in;
         count_ff    <= count_in;
      end
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   assign rsp_status           = status_ff;
   assign rsp_granted_id       = granted_ff;
   assign rsp_free_count_audio = count_ff[0];
   assign rsp_free_count_host  = count_ff[1];
   assign rsp_free_count_track = count_ff[2];

   // A free counter never exceeds the pool size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (count_ff[0] <= tpsa_pkg::COUNT_W'(tpsa_pkg::POOL_ENTRIES)) &&
      (count_ff[1] <= tpsa_pkg::COUNT_W'(tpsa_pkg::POOL_ENTRIES)) &&
      (count_ff[2] <= tpsa_pkg::COUNT_W'(tpsa_pkg::POOL_ENTRIES)))
      else $error("free counter above pool size");

   // A successful reserve hands out a slot that was free
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && (func_ff == tpsa_pkg::FUNC_RESERVE) && pool_valid && (tgt_map != '0))
      |-> tgt_map[low_slot])
      else $error("reserved slot was not free");

   // Pool state moves only on an executed request
   a_quiet_state: assert property (@(posedge clock) disable iff (reset)
      !cmd.exec |=> $stable(count_ff[0]) && $stable(count_ff[1]) && $stable(count_ff[2]))
      else $error("free count changed without a request");

endmodule

// ===== src/tpsa_ctrl.sv =====
// Controller: accept / execute sequencing and response valid.
module tpsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tpsa_pkg::dp_cmd_type  cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // The response register can take a new result when empty or being drained
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign cmd.load  = req_ready && req_valid;
   assign cmd.exec  = (state_ff == ST_EXEC) && out_free;

   // Next state
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // An accepted request moves to execution
   a_load_exec: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   // Execution always leaves a result waiting
   a_exec_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid_ff)
      else $error("executed request gave no result");

   // A pending result is never overwritten
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !cmd.exec)
      else $error("pending result overwritten");

endmodule

// ===== src/three_pool_slot_allocator.sv =====
// Top level of the three-pool slot allocator: controller plus datapath.
// A request is captured on acceptance, then executed once the response register can take a result.
// A new request is accepted only after the previous one has executed (accept then execute steps).
// A new request is accepted while the previous result still waits in the response register.
// Reset: synchronous; every slot of all three pools is free, counts read POOL_ENTRIES,
// no result pending.
module three_pool_slot_allocator (
   input  logic       clock,
   input  logic       reset,
   tpsa_req_if.sink   req_bus,
   tpsa_rsp_if.source rsp_bus
);

   tpsa_pkg::dp_cmd_type cmd;

   // Sequencing
   tpsa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   // Pool state and results
   tpsa_datapath u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .req_func             (req_bus.func),
      .req_pool_select      (req_bus.pool_select),
      .req_item_id          (req_bus.item_id),
      .rsp_status           (rsp_bus.status),
      .rsp_granted_id       (rsp_bus.granted_id),
      .rsp_free_count_audio (rsp_bus.free_count_audio),
      .rsp_free_count_host  (rsp_bus.free_count_host),
      .rsp_free_count_track (rsp_bus.free_count_track)
   );

endmodule

// ===== dv/tb_three_pool_slot_allocator.sv =====
// Testbench of the three-pool slot allocator: directed and random requests checked by prediction.
`timescale 1ns / 100ps

module tb_three_pool_slot_allocator;

   localparam int STALL_LIMIT = 1000;   // cycles with no handshake before giving up
   localparam int END_SETTLE  = 8;

   // One response as the block should report it
   typedef struct packed {
      logic [tpsa_pkg::STATUS_W-1:0] status;
      logic [tpsa_pkg::ID_W-1:0]     granted_id;
      logic [tpsa_pkg::COUNT_W-1:0]  free_audio;
      logic [tpsa_pkg::COUNT_W-1:0]  free_host;
      logic [tpsa_pkg::COUNT_W-1:0]  free_track;
   } slot_result_type;

   logic clock = 1'b0;
   logic reset;

   tpsa_req_if req_bus ();
   tpsa_rsp_if rsp_bus ();

   three_pool_slot_allocator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // Predicted allocator state: one free map per pool, set bit = slot free
   tpsa_pkg::pool_map_type     free_map [tpsa_pkg::POOL_COUNT];
   slot_result_type            pending_results [$];
   logic [tpsa_pkg::ID_W-1:0]  held_ids [$];       // ids granted and not yet handed back
   int                         mismatch_count = 0;
   int                         quiet_cycles   = 0;
   bit                         sender_idles   = 1'b1;
   bit                         sink_stalls    = 1'b1;

   always #5 clock = ~clock;

   // Work out the response to one accepted request and update the predicted maps
   function automatic slot_result_type predict_allocation(
      input logic [tpsa_pkg::FUNC_W-1:0] func,
      input logic [tpsa_pkg::POOL_W-1:0] pool,
      input logic [tpsa_pkg::ID_W-1:0]   id);
      slot_result_type res;
      int              slot;
      int              owner;
      res = '0;
      res.status = tpsa_pkg::STATUS_OK;
      if (func == tpsa_pkg::FUNC_RESERVE) begin
         if (pool == tpsa_pkg::POOL_NONE || free_map[pool] == '0) begin
            res.status = tpsa_pkg::STATUS_EMPTY;
         end else begin
            slot = 0;
            while (!free_map[pool][slot]) slot++;
            free_map[pool][slot] = 1'b0;
            res.granted_id = tpsa_pkg::ID_W'(int'(pool) * tpsa_pkg::POOL_ENTRIES + slot);
            held_ids.insert(held_ids.size(), res.granted_id);
         end
      end else if ({1'b0, id} >= tpsa_pkg::ID_LIMIT) begin
         res.status = tpsa_pkg::STATUS_RANGE;
      end else begin
         owner = int'(id) / tpsa_pkg::POOL_ENTRIES;
         slot  = int'(id) % tpsa_pkg::POOL_ENTRIES;
         free_map[owner][slot] = 1'b1;   // already free: no change
      end
      res.free_audio = tpsa_pkg::COUNT_W'($countones(free_map[0]));
      res.free_host  = tpsa_pkg::COUNT_W'($countones(free_map[1]));
      res.free_track = tpsa_pkg::COUNT_W'($countones(free_map[2]));
      return res;
   endfunction

   // Hand back a random one of the ids currently held
   function automatic logic [tpsa_pkg::ID_W-1:0] take_held_id();
      int                        idx;
      logic [tpsa_pkg::ID_W-1:0] id;
      idx = $urandom_range(0, held_ids.size() - 1);
      id  = held_ids[idx];
      held_ids.delete(idx);
      return id;
   endfunction

   // Drive one request, wait for acceptance, then record its expected response
   task automatic issue_request(input logic [tpsa_pkg::FUNC_W-1:0] func,
                                input logic [tpsa_pkg::POOL_W-1:0] pool,
                                input logic [tpsa_pkg::ID_W-1:0]   id);
      if (sender_idles && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.func        <= func;
      req_bus.pool_select <= pool;
      req_bus.item_id     <= id;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.insert(pending_results.size(), predict_allocation(func, pool, id));
   endtask

   task automatic reserve_from(input logic [tpsa_pkg::POOL_W-1:0] pool);
      issue_request(tpsa_pkg::FUNC_RESERVE, pool, tpsa_pkg::ID_W'($urandom_range(0, 255)));
   endtask

   task automatic free_slot(input logic [tpsa_pkg::ID_W-1:0] id);
      issue_request(tpsa_pkg::FUNC_FREE, tpsa_pkg::POOL_W'($urandom_range(0, 3)), id);
   endtask

   // One random request; reserve_pct sets the share of reserves
   task automatic issue_random_request(input int reserve_pct);
      int pick;
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < reserve_pct) begin
         if (pick < 6) reserve_from(tpsa_pkg::POOL_NONE);
         else reserve_from(tpsa_pkg::POOL_W'($urandom_range(0, 2)));
      end else if (held_ids.size() != 0 && pick < 75) begin
         free_slot(take_held_id());
      end else if (pick < 90) begin
         free_slot(tpsa_pkg::ID_W'($urandom_range(0, int'(tpsa_pkg::ID_LIMIT) - 1)));
      end else begin
         free_slot(tpsa_pkg::ID_W'($urandom_range(0, 255)));
      end
   endtask

   // Field extremes, both operations, missing pool, out-of-range and double free
   task automatic test_directed();
      reserve_from(tpsa_pkg::POOL_AUDIO);
      reserve_from(tpsa_pkg::POOL_HOST);
      reserve_from(tpsa_pkg::POOL_TRACK);
      reserve_from(tpsa_pkg::POOL_NONE);
      reserve_from(tpsa_pkg::POOL_AUDIO);
      free_slot(8'd0);
      free_slot(8'd0);
      reserve_from(tpsa_pkg::POOL_AUDIO);
      free_slot(8'd255);
      free_slot(tpsa_pkg::ID_W'(tpsa_pkg::ID_LIMIT));
      free_slot(tpsa_pkg::ID_W'(tpsa_pkg::ID_LIMIT - 1));
      free_slot(tpsa_pkg::ID_W'(tpsa_pkg::POOL1_BASE));
      free_slot(tpsa_pkg::ID_W'(tpsa_pkg::POOL1_BASE - 1));
      free_slot(tpsa_pkg::ID_W'(tpsa_pkg::POOL2_BASE - 1));
      free_slot(tpsa_pkg::ID_W'(tpsa_pkg::POOL2_BASE));
      issue_request(tpsa_pkg::FUNC_RESERVE, tpsa_pkg::POOL_TRACK, 8'hFF);
      issue_request(tpsa_pkg::FUNC_RESERVE, tpsa_pkg::POOL_NONE, 8'h00);
      issue_request(tpsa_pkg::FUNC_FREE, tpsa_pkg::POOL_NONE, 8'd1);
      free_slot(8'd0);
   endtask

   // Empty every pool in turn, over-reserve, then give every slot back
   task automatic test_drain_and_refill();
      logic [tpsa_pkg::POOL_W-1:0] pool;
      for (int p = 0; p < tpsa_pkg::POOL_COUNT; p++) begin
         pool = tpsa_pkg::POOL_W'(p);
         while (free_map[p] != '0) begin
            if ($urandom_range(0, 9) == 0) begin
               if ($urandom_range(0, 1) == 0) reserve_from(tpsa_pkg::POOL_NONE);
               else free_slot(tpsa_pkg::ID_W'($urandom_range(int'(tpsa_pkg::ID_LIMIT), 255)));
            end
            reserve_from(pool);
         end
         reserve_from(pool);
         reserve_from(pool);
      end
      while (held_ids.size() != 0) begin
         if ($urandom_range(0, 15) == 0) begin
            free_slot(tpsa_pkg::ID_W'($urandom_range(0, int'(tpsa_pkg::ID_LIMIT) - 1)));
         end
         free_slot(take_held_id());
      end
   endtask

   // Random mix with idling on both sides; the reserve share drifts per block
   task automatic test_random_mix();
      int reserve_pct;
      for (int blk = 0; blk < 13; blk++) begin
         reserve_pct = $urandom_range(20, 80);
         repeat (50) issue_random_request(reserve_pct);
      end
   endtask

   // Back-to-back requests with no idling on either side
   task automatic test_random_burst();
      sender_idles = 1'b0;
      sink_stalls  = 1'b0;
      repeat (250) issue_random_request($urandom_range(30, 70));
      req_bus.valid <= 1'b0;
   endtask

   // Stimulus and end of run
   initial begin
      for (int p = 0; p < tpsa_pkg::POOL_COUNT; p++) free_map[p] = '1;
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.func        <= tpsa_pkg::FUNC_RESERVE;
      req_bus.pool_select <= tpsa_pkg::POOL_AUDIO;
      req_bus.item_id     <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_drain_and_refill();
      test_random_mix();
      test_random_burst();
      while (pending_results.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Response ready with random stall bursts
   initial begin
      rsp_bus.ready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (sink_stalls && $urandom_range(0, 2) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   task automatic check_field(input string field, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_responses
      slot_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("response accepted with no request outstanding");
            mismatch_count++;
         end else begin
            want = pending_results.pop_front();
            check_field("status", want.status, rsp_bus.status);
            check_field("granted_id", want.granted_id, rsp_bus.granted_id);
            check_field("free_count_audio", want.free_audio, rsp_bus.free_count_audio);
            check_field("free_count_host", want.free_host, rsp_bus.free_count_host);
            check_field("free_count_track", want.free_track, rsp_bus.free_count_track);
         end
      end
   end

   // Watchdog: give up after a long stretch with no handshake on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
